// File: design/b2f_pkg.sv
// Shared types, constants and register indexes of the Burgers FTCS stencil.
package b2f_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned WIDE_W = 64;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t WIDE_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] CFG_GRID_ROWS = 3'd0;
  localparam logic [2:0] CFG_GRID_COLS = 3'd1;
  localparam logic [2:0] CFG_ADV_ROW   = 3'd2;
  localparam logic [2:0] CFG_ADV_COL   = 3'd3;
  localparam logic [2:0] CFG_DIFF_ROW  = 3'd4;
  localparam logic [2:0] CFG_DIFF_COL  = 3'd5;
  localparam logic [2:0] CFG_VISCOSITY = 3'd6;
  localparam logic [2:0] CFG_AV_COEF   = 3'd7;

  typedef struct packed {
    val_t n;
    val_t s;
    val_t e;
    val_t w;
    val_t c;
  } cross_t;

  typedef struct packed {
    logic [31:0] adv_row;
    logic [31:0] adv_col;
    logic [31:0] diff_row;
    logic [31:0] diff_col;
    logic [31:0] viscosity;
    logic [31:0] av_coef;
  } coef_t;

  typedef struct packed {
    val_t u_new;
    val_t v_new;
  } result_t;

endpackage

// File: design/burgers_2d_ftcs_stencil_core.sv
// Top level of the streaming 2D Burgers FTCS stencil core.
// Boundary point: after the input transfer the core passes S_READ and returns to S_IDLE to take the next point.
// Interior point: the time to the result is set by the shared iterative
// multiplier, which forms fifteen rounded products one after another.
// A finished result waits in the output register while the next point is taken.
// Reset clears counters, window and registers (grid 3x3, coefficients 0);
// the line memory is not cleared and is valid once written.
module burgers_2d_ftcs_stencil_core #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // u_in[31:0], v_in[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // u_new[31:0], v_new[63:32]
  output logic        m_axis_tlast   // grid_done
);

  localparam int unsigned CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned LCW_R    = $clog2(MAX_COLS + 1);
  localparam int unsigned LCW      = (LCW_R > 11) ? LCW_R : 11;
  localparam int unsigned OUT_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [15:0] grid_rows_q;
  logic [10:0] grid_cols_q;
  b2f_pkg::coef_t coef_q;

  logic [1:0]    state_q;
  logic [CW-1:0] col_q, c_q;
  logic [15:0]   row_q, r_q;
  b2f_pkg::val_t uin_q, vin_q;
  logic          last_q;
  b2f_pkg::val_t uw_q [9];
  b2f_pkg::val_t vw_q [9];

  logic          out_valid_q, out_last_q;
  b2f_pkg::result_t out_q;

  logic [LCW-1:0] cols_eff;
  logic [15:0]    rows_eff;
  logic [CW-1:0]  c_cl;
  logic [15:0]    r_cl;
  logic           accept, last_col, last_row, interior;
  logic [127:0]   rd_data, wr_data;
  b2f_pkg::cross_t cu, cv;
  logic           upd_start, upd_done, upd_ack;
  b2f_pkg::result_t upd_res;

  always_comb begin
    cols_eff = LCW'(grid_cols_q);
    if (cols_eff < LCW'(3)) begin
      cols_eff = LCW'(3);
    end else if (cols_eff > LCW'(MAX_COLS)) begin
      cols_eff = LCW'(MAX_COLS);
    end
    rows_eff = (grid_rows_q < 16'd3) ? 16'd3 : grid_rows_q;
    c_cl     = (LCW'(col_q) >= cols_eff) ? CW'(cols_eff - LCW'(1)) : col_q;
    r_cl     = (row_q >= rows_eff) ? rows_eff - 16'd1 : row_q;
    last_col = (LCW'(c_q) == cols_eff - LCW'(1));
    last_row = (r_q == rows_eff - 16'd1);
    interior = (r_q >= 16'd2) && (LCW'(c_q) >= LCW'(2));
    accept   = s_axis_tvalid && s_axis_tready;
    wr_data  = {vin_q, rd_data[127:96], uin_q, rd_data[63:32]};
    upd_start = (state_q == S_CALC);
    upd_ack   = (state_q == S_WAIT) && upd_done && (!out_valid_q || m_axis_tready);
  end

  assign s_axis_tready = (state_q == S_IDLE);

  b2f_line_mem #(
    .DEPTH (MAX_COLS),
    .AW    (CW),
    .DW    (128)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_cl),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == S_READ),
    .wr_addr_i (c_q),
    .wr_data_i (wr_data)
  );

  assign cu = '{n: uw_q[1], s: uw_q[7], e: uw_q[5], w: uw_q[3], c: uw_q[4]};
  assign cv = '{n: vw_q[1], s: vw_q[7], e: vw_q[5], w: vw_q[3], c: vw_q[4]};

  b2f_update #(
    .OUT_BITS (OUT_BITS)
  ) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (upd_start),
    .cu_i    (cu),
    .cv_i    (cv),
    .coef_i  (coef_q),
    .ack_i   (upd_ack),
    .done_o  (upd_done),
    .res_o   (upd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 16'd3;
      grid_cols_q <= 11'd3;
      coef_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        b2f_pkg::CFG_GRID_ROWS: grid_rows_q      <= cfg_data_i[15:0];
        b2f_pkg::CFG_GRID_COLS: grid_cols_q      <= cfg_data_i[10:0];
        b2f_pkg::CFG_ADV_ROW:   coef_q.adv_row   <= cfg_data_i;
        b2f_pkg::CFG_ADV_COL:   coef_q.adv_col   <= cfg_data_i;
        b2f_pkg::CFG_DIFF_ROW:  coef_q.diff_row  <= cfg_data_i;
        b2f_pkg::CFG_DIFF_COL:  coef_q.diff_col  <= cfg_data_i;
        b2f_pkg::CFG_VISCOSITY: coef_q.viscosity <= cfg_data_i;
        b2f_pkg::CFG_AV_COEF:   coef_q.av_coef   <= cfg_data_i;
        default: coef_q <= coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        uw_q[i] <= '0;
        vw_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          for (int k = 0; k < 3; k++) begin
            uw_q[k*3]   <= uw_q[k*3+1];
            uw_q[k*3+1] <= uw_q[k*3+2];
            vw_q[k*3]   <= vw_q[k*3+1];
            vw_q[k*3+1] <= vw_q[k*3+2];
          end
          uw_q[2] <= rd_data[31:0];
          uw_q[5] <= rd_data[63:32];
          uw_q[8] <= uin_q;
          vw_q[2] <= rd_data[95:64];
          vw_q[5] <= rd_data[127:96];
          vw_q[8] <= vin_q;
          if (last_col) begin
            col_q <= '0;
            row_q <= last_row ? 16'd0 : r_q + 16'd1;
          end else begin
            col_q <= c_q + CW'(1);
            row_q <= r_q;
          end
          state_q <= interior ? S_CALC : S_IDLE;
        end
        S_CALC: state_q <= S_WAIT;
        S_WAIT: begin
          if (upd_ack) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      uin_q <= s_axis_tdata[31:0];
      vin_q <= s_axis_tdata[63:32];
      c_q   <= c_cl;
      r_q   <= r_cl;
    end
    if (state_q == S_READ) begin
      last_q <= last_col && last_row;
    end
    if (upd_ack) begin
      out_q      <= upd_res;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.v_new, out_q.u_new};
  assign m_axis_tlast  = out_last_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("input transfer not followed by line read");

  a_boundary_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && !interior) |=> s_axis_tready)
    else $error("boundary point did not release input");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_done |-> (state_q == S_WAIT))
    else $error("update finished outside wait state");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_ack |=> m_axis_tvalid)
    else $error("result load did not raise output valid");

endmodule

// File: design/b2f_line_mem.sv
// Line store: two previous rows of u and v per column, one write and one registered read port.
module b2f_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 128
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/b2f_qmul.sv
// Iterative signed Q48.16 multiplier: four 32x32 partial products, rounding and saturation.
module b2f_qmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  b2f_pkg::wide_t a_i,
  input  b2f_pkg::wide_t b_i,
  output logic          done_o,
  output b2f_pkg::wide_t p_o
);

  logic [61:0]  xm_q, ym_q;
  logic         neg_q;
  logic [124:0] acc_q;
  logic [1:0]   cnt_q;
  logic         run_q, fin_q, done_q;
  b2f_pkg::wide_t p_q;

  b2f_pkg::wide_t a_abs, b_abs;
  logic [31:0]  xp, yp;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [124:0] pp_sh;
  logic         sat;
  logic [61:0]  mag;

  always_comb begin
    a_abs = a_i[63] ? -a_i : a_i;
    b_abs = b_i[63] ? -b_i : b_i;
    xp    = cnt_q[0] ? {2'b00, xm_q[61:32]} : xm_q[31:0];
    yp    = cnt_q[1] ? {2'b00, ym_q[61:32]} : ym_q[31:0];
    pp    = 64'(xp) * 64'(yp);
    sh    = 7'(({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}) * 32);
    pp_sh = {61'd0, pp} << sh;
    sat   = |acc_q[124:78];
    mag   = sat ? 62'h3FFF_FFFF_FFFF_FFFF : acc_q[77:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xm_q  <= a_abs[61:0];
      ym_q  <= b_abs[61:0];
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= 125'h8000;
    end else if (run_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      p_q <= neg_q ? -b2f_pkg::wide_t'({2'b00, mag}) : b2f_pkg::wide_t'({2'b00, mag});
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// File: design/b2f_update.sv
// FTCS update sequencer: steps fifteen products through the shared multiplier.
module b2f_update #(
  parameter int unsigned OUT_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  b2f_pkg::cross_t  cu_i,
  input  b2f_pkg::cross_t  cv_i,
  input  b2f_pkg::coef_t   coef_i,
  input  logic             ack_i,
  output logic             done_o,
  output b2f_pkg::result_t res_o
);

  localparam logic [3:0] OP_DUX = 4'd0;
  localparam logic [3:0] OP_DUY = 4'd1;
  localparam logic [3:0] OP_DVX = 4'd2;
  localparam logic [3:0] OP_DVY = 4'd3;
  localparam logic [3:0] OP_M1  = 4'd4;
  localparam logic [3:0] OP_M2  = 4'd5;
  localparam logic [3:0] OP_M3  = 4'd6;
  localparam logic [3:0] OP_M4  = 4'd7;
  localparam logic [3:0] OP_AV  = 4'd8;
  localparam logic [3:0] OP_LRU = 4'd9;
  localparam logic [3:0] OP_LCU = 4'd10;
  localparam logic [3:0] OP_MU  = 4'd11;
  localparam logic [3:0] OP_LRV = 4'd12;
  localparam logic [3:0] OP_LCV = 4'd13;
  localparam logic [3:0] OP_MV  = 4'd14;

  localparam b2f_pkg::wide_t OUT_HI = b2f_pkg::wide_t'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam b2f_pkg::wide_t OUT_LO = -OUT_HI - 64'sd1;

  function automatic b2f_pkg::wide_t sx(input b2f_pkg::val_t x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic b2f_pkg::wide_t zx(input logic [31:0] x);
    return {32'd0, x};
  endfunction

  function automatic b2f_pkg::wide_t add_sat(input b2f_pkg::wide_t a, input b2f_pkg::wide_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'(b2f_pkg::WIDE_LIM)) begin
      return b2f_pkg::WIDE_LIM;
    end else if (s < -65'(b2f_pkg::WIDE_LIM)) begin
      return -b2f_pkg::WIDE_LIM;
    end
    return s[63:0];
  endfunction

  function automatic b2f_pkg::val_t sat_out(input b2f_pkg::wide_t x);
    if (x > OUT_HI) begin
      return OUT_HI[31:0];
    end else if (x < OUT_LO) begin
      return OUT_LO[31:0];
    end
    return x[31:0];
  endfunction

  logic [3:0]     op_q;
  logic           busy_q, mstart_q, done_q;
  b2f_pkg::wide_t dux_q, duy_q, dvx_q, dvy_q, comp_q, t1_q;
  b2f_pkg::wide_t adv_u_q, adv_v_q, visc_q, lap_q, base_q;
  b2f_pkg::val_t  un_q, vn_q;

  b2f_pkg::wide_t opa, opb, p;
  logic           mdone;

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_q)
      OP_DUX: begin opa = zx(coef_i.adv_row); opb = sx(cu_i.s) - sx(cu_i.n); end
      OP_DUY: begin opa = zx(coef_i.adv_col); opb = sx(cu_i.e) - sx(cu_i.w); end
      OP_DVX: begin opa = zx(coef_i.adv_row); opb = sx(cv_i.s) - sx(cv_i.n); end
      OP_DVY: begin opa = zx(coef_i.adv_col); opb = sx(cv_i.e) - sx(cv_i.w); end
      OP_M1:  begin opa = sx(cu_i.c); opb = dux_q; end
      OP_M2:  begin opa = sx(cv_i.c); opb = duy_q; end
      OP_M3:  begin opa = sx(cu_i.c); opb = dvx_q; end
      OP_M4:  begin opa = sx(cv_i.c); opb = dvy_q; end
      OP_AV:  begin opa = zx(coef_i.av_coef); opb = comp_q[63] ? -comp_q : '0; end
      OP_LRU: begin
        opa = zx(coef_i.diff_row);
        opb = sx(cu_i.s) - (sx(cu_i.c) <<< 1) + sx(cu_i.n);
      end
      OP_LCU: begin
        opa = zx(coef_i.diff_col);
        opb = sx(cu_i.e) - (sx(cu_i.c) <<< 1) + sx(cu_i.w);
      end
      OP_MU:  begin opa = visc_q; opb = lap_q; end
      OP_LRV: begin
        opa = zx(coef_i.diff_row);
        opb = sx(cv_i.s) - (sx(cv_i.c) <<< 1) + sx(cv_i.n);
      end
      OP_LCV: begin
        opa = zx(coef_i.diff_col);
        opb = sx(cv_i.e) - (sx(cv_i.c) <<< 1) + sx(cv_i.w);
      end
      OP_MV:  begin opa = visc_q; opb = lap_q; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  b2f_qmul u_qmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mdone),
    .p_o     (p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      mstart_q <= 1'b0;
      done_q   <= 1'b0;
      op_q     <= OP_DUX;
    end else begin
      mstart_q <= 1'b0;
      if (ack_i) begin
        done_q <= 1'b0;
      end
      if (start_i) begin
        busy_q   <= 1'b1;
        op_q     <= OP_DUX;
        mstart_q <= 1'b1;
      end else if (busy_q && mdone) begin
        if (op_q == OP_MV) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          op_q     <= op_q + 4'd1;
          mstart_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && mdone) begin
      case (op_q)
        OP_DUX: dux_q <= p;
        OP_DUY: duy_q <= p;
        OP_DVX: dvx_q <= p;
        OP_DVY: begin dvy_q <= p; comp_q <= add_sat(dux_q, p); end
        OP_M1:  t1_q <= p;
        OP_M2:  adv_u_q <= add_sat(t1_q, p);
        OP_M3:  t1_q <= p;
        OP_M4:  adv_v_q <= add_sat(t1_q, p);
        OP_AV:  visc_q <= add_sat(zx(coef_i.viscosity), p);
        OP_LRU: begin t1_q <= p; base_q <= add_sat(sx(cu_i.c), -adv_u_q); end
        OP_LCU: lap_q <= add_sat(t1_q, p);
        OP_MU:  un_q <= sat_out(add_sat(base_q, p));
        OP_LRV: begin t1_q <= p; base_q <= add_sat(sx(cv_i.c), -adv_v_q); end
        OP_LCV: lap_q <= add_sat(t1_q, p);
        OP_MV:  vn_q <= sat_out(add_sat(base_q, p));
        default: t1_q <= t1_q;
      endcase
    end
  end

  assign done_o      = done_q;
  assign res_o.u_new = un_q;
  assign res_o.v_new = vn_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Burgers FTCS stencil core: predicts each update and compares.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCOLS = 1024;
  localparam int unsigned WDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  burgers_2d_ftcs_stencil_core dut (.*);

  always #4 clk_i = ~clk_i;

  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic        done;
  } update_t;

  logic [63:0] point_q[$];
  update_t     update_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          feed_on = 1'b0;

  // predictor state
  logic [31:0]     regs [8];
  b2f_pkg::wide_t  uline [2*NCOLS];
  b2f_pkg::wide_t  vline [2*NCOLS];
  b2f_pkg::wide_t  uwin [9];
  b2f_pkg::wide_t  vwin [9];
  int unsigned     ccnt, rcnt;

  function automatic b2f_pkg::wide_t clampw(b2f_pkg::wide_t x);
    if (x > b2f_pkg::WIDE_LIM) return b2f_pkg::WIDE_LIM;
    if (x < -b2f_pkg::WIDE_LIM) return -b2f_pkg::WIDE_LIM;
    return x;
  endfunction

  function automatic b2f_pkg::wide_t addw(b2f_pkg::wide_t a, b2f_pkg::wide_t b);
    return clampw(clampw(a) + clampw(b));
  endfunction

  function automatic b2f_pkg::wide_t qmul(b2f_pkg::wide_t a, b2f_pkg::wide_t b);
    logic [63:0]  x, y;
    logic [127:0] p;
    logic [63:0]  r;
    bit           neg;
    a = clampw(a);
    b = clampw(b);
    neg = (a < 0) != (b < 0);
    x = a < 0 ? -a : a;
    y = b < 0 ? -b : b;
    p = x * y + 128'h8000;
    p = p >> 16;
    if (p > 128'(b2f_pkg::WIDE_LIM)) r = b2f_pkg::WIDE_LIM;
    else r = p[63:0];
    return neg ? -b2f_pkg::wide_t'(r) : b2f_pkg::wide_t'(r);
  endfunction

  function automatic b2f_pkg::wide_t lap(b2f_pkg::wide_t w[9]);
    b2f_pkg::wide_t c2;
    c2 = 2 * w[4];
    return addw(qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_DIFF_ROW]), w[7] - c2 + w[1]),
                qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_DIFF_COL]), w[5] - c2 + w[3]));
  endfunction

  function automatic logic [31:0] sat32(b2f_pkg::wide_t x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic void predict_point(logic [63:0] pt);
    int unsigned rows, cols, r, c;
    b2f_pkg::wide_t uin, vin, uc, vc, dux, duy, dvx, dvy, adu, adv, comp, av, visc;
    update_t e;
    rows = regs[b2f_pkg::CFG_GRID_ROWS][15:0] < 3 ? 3 : regs[b2f_pkg::CFG_GRID_ROWS][15:0];
    cols = regs[b2f_pkg::CFG_GRID_COLS][10:0];
    if (cols < 3) cols = 3;
    if (cols > NCOLS) cols = NCOLS;
    r = rcnt < rows ? rcnt : rows - 1;
    c = ccnt < cols ? ccnt : cols - 1;
    uin = b2f_pkg::wide_t'($signed(pt[31:0]));
    vin = b2f_pkg::wide_t'($signed(pt[63:32]));
    for (int k = 0; k < 3; k++) begin
      uwin[k*3] = uwin[k*3+1]; uwin[k*3+1] = uwin[k*3+2];
      vwin[k*3] = vwin[k*3+1]; vwin[k*3+1] = vwin[k*3+2];
    end
    uwin[2] = uline[c]; uwin[5] = uline[NCOLS+c]; uwin[8] = uin;
    vwin[2] = vline[c]; vwin[5] = vline[NCOLS+c]; vwin[8] = vin;
    uline[c] = uline[NCOLS+c]; uline[NCOLS+c] = uin;
    vline[c] = vline[NCOLS+c]; vline[NCOLS+c] = vin;
    if (r >= 2 && c >= 2) begin
      uc = uwin[4]; vc = vwin[4];
      dux = qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_ADV_ROW]), uwin[7] - uwin[1]);
      duy = qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_ADV_COL]), uwin[5] - uwin[3]);
      dvx = qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_ADV_ROW]), vwin[7] - vwin[1]);
      dvy = qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_ADV_COL]), vwin[5] - vwin[3]);
      adu = addw(qmul(uc, dux), qmul(vc, duy));
      adv = addw(qmul(uc, dvx), qmul(vc, dvy));
      comp = addw(dux, dvy);
      av = comp < 0 ? qmul(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_AV_COEF]), -comp) : 0;
      visc = addw(b2f_pkg::wide_t'(regs[b2f_pkg::CFG_VISCOSITY]), av);
      e.u = sat32(addw(addw(uc, -adu), qmul(visc, lap(uwin))));
      e.v = sat32(addw(addw(vc, -adv), qmul(visc, lap(vwin))));
      e.done = (r == rows - 1 && c == cols - 1);
      update_q.push_back(e);
    end
    if (c == cols - 1) begin
      ccnt = 0;
      rcnt = (r == rows - 1) ? 0 : r + 1;
    end else begin
      ccnt = c + 1;
      rcnt = r;
    end
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_point(s_axis_tdata);
      void'(point_q.pop_front());
      send_gap = gap_len();
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (feed_on && point_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= point_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (update_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        update_t e;
        e = update_q.pop_front();
        if (m_axis_tdata[31:0] !== e.u || m_axis_tdata[63:32] !== e.v ||
            m_axis_tlast !== e.done) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp u=%h v=%h last=%b got u=%h v=%h last=%b",
                     e.u, e.v, e.done, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tlast);
        end
      end
      recv_gap = gap_len();
    end
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == b2f_pkg::CFG_GRID_ROWS) regs[idx] = val & 32'hFFFF;
    else if (idx == b2f_pkg::CFG_GRID_COLS) regs[idx] = val & 32'h7FF;
    else regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (point_q.size() != 0 || update_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic run_grid(int rows, int cols, bit directed);
    for (int i = 0; i < rows * cols; i++) begin
      if (directed)
        point_q.push_back({(i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                           (i % 3) ? 32'h7FFF_FFFF : 32'h8000_0000});
      else
        point_q.push_back({rand_val(), rand_val()});
    end
  endtask

  task automatic set_coefs(bit extreme);
    for (int k = 2; k < 8; k++)
      write_reg(3'(k), extreme ? 32'hFFFF_FFFF : $urandom_range(32'h3_0000));
  endtask

  initial begin
    int rows, cols;
    for (int k = 0; k < 8; k++) regs[k] = 0;
    regs[b2f_pkg::CFG_GRID_ROWS] = 3;
    regs[b2f_pkg::CFG_GRID_COLS] = 3;
    for (int k = 0; k < 2*NCOLS; k++) begin
      uline[k] = 0;
      vline[k] = 0;
    end
    for (int k = 0; k < 9; k++) begin
      uwin[k] = 0;
      vwin[k] = 0;
    end
    ccnt = 0;
    rcnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    feed_on = 1'b1;
    // reset geometry, zero coefficients, extremes
    run_grid(3, 3, 1'b1);
    drain();
    set_coefs(1'b1);
    run_grid(3, 3, 1'b1);
    drain();
    // out-of-range geometry clamps to 3x3
    write_reg(b2f_pkg::CFG_GRID_ROWS, 32'd0);
    write_reg(b2f_pkg::CFG_GRID_COLS, 32'd1);
    set_coefs(1'b0);
    run_grid(3, 3, 1'b0);
    drain();
    // random grids; extra points cross into the next grid and exercise wrap
    for (int g = 0; g < 14; g++) begin
      rows = $urandom_range(6, 3);
      cols = $urandom_range(8, 3);
      write_reg(b2f_pkg::CFG_GRID_ROWS, rows);
      write_reg(b2f_pkg::CFG_GRID_COLS, cols);
      set_coefs($urandom_range(9) == 0);
      run_grid(rows, cols, 1'b0);
      if (g % 4 == 3) run_grid(rows, cols, 1'b0);
      drain();
    end
    write_reg(b2f_pkg::CFG_GRID_ROWS, 32'hFFFF);
    write_reg(b2f_pkg::CFG_GRID_COLS, 32'd3);
    run_grid(4, 3, 1'b0);
    drain();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: burgers_2d_ftcs_stencil_core.f
design/b2f_pkg.sv
design/b2f_line_mem.sv
design/b2f_qmul.sv
design/b2f_update.sv
design/burgers_2d_ftcs_stencil_core.sv
tb/tb_top.sv
